// ----- sv/xxh_pkg.sv -----
// xxh_pkg: constants and helper functions for the three-operand XXH32 seed unit.
// Standalone package; imported by xxhash32_three_operand_seed_unit, xxh_seed_checker and tb.

package xxh_pkg;

  // XXH32 primes
  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;

  // Modulus 2^31-1 and message length in bytes
  localparam logic [30:0] MOD31     = 31'h7FFF_FFFF;
  localparam logic [31:0] MSG_BYTES = 32'd20;

  // Number of operand lanes and pipeline depth
  localparam int NUM_LANES = 3;
  localparam int NUM_STAGES = 14;

  typedef logic [31:0] word_t;

  function automatic word_t rotl32(input word_t x, input int n);
    word_t r;
    r = (x << n) | (x >> (32 - n));
    return r;
  endfunction

  // One XXH32 lane round on a constant word (elaboration only)
  function automatic word_t lane_round(input word_t acc, input word_t w);
    word_t a;
    word_t m;
    m = w * PRIME2;
    a = acc + m;
    a = rotl32(a, 13);
    return word_t'(a * PRIME1);
  endfunction

  // Lane accumulator seeds for seed 0
  localparam word_t LANE_INIT [NUM_LANES] = '{
    word_t'(PRIME1 + PRIME2), PRIME2, 32'd0
  };
  localparam int LANE_ROT [NUM_LANES] = '{1, 7, 12};

  // Fourth lane sees a zero word, so its rotated share plus the length is fixed.
  // The fifth word is zero too, so the tail step adds nothing.
  localparam word_t LANE4_ZERO = lane_round(word_t'(32'd0 - PRIME1), 32'd0);
  localparam word_t MERGE_CONST = word_t'(rotl32(LANE4_ZERO, 18) + MSG_BYTES);

endpackage

// ----- sv/xxhash32_three_operand_seed_unit.sv -----
// xxhash32_three_operand_seed_unit
// Reduces three signed 64-bit operands mod 2^31-1 (sign kept), then hashes them
// plus two zero words with XXH32 seed 0. Depends on xxh_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word of three signed 64-bit
//   operands. Output channel (out_valid/out_ready) returns one 32-bit hash per
//   input word, in order.
//   Output: out_hash_value comes from the last stage register, out_valid from
//   its valid bit. Throughput: one word per cycle unless stalled; the 14-stage
//   pipeline holds up to 14 words in flight. Each stage has about one 32-bit
//   multiply or one wide add.
//   Stall: when out_valid is high and out_ready low, the whole pipeline holds
//   and in_ready drops in the same cycle; nothing is lost or repeated.
//   Stages: 1 abs value, 2 31-bit chunk sum, 3 fold, 4 compare-subtract,
//   5 sign restore, 6 word*P2, 7 add+rot13, 8 *P1, 9 partial merge,
//   10 merge+rot17, 11 *P4, 12 xorshift+*P2, 13 xorshift+*P3, 14 xorshift.
//   Reset: synchronous active-low rst_n clears all stage valid bits;
//   payload registers are not reset.
//   No configuration registers; no state carried between words.

module xxhash32_three_operand_seed_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  input  logic signed [63:0] in_operand_c,
  output logic               out_valid,
  input  logic               out_ready,
  output xxh_pkg::word_t     out_hash_value
);

  import xxh_pkg::*;

  // Global advance: pipeline moves when the output slot is free or drained
  logic adv;
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;

  assign adv      = !vld_r[NUM_STAGES-1] || out_ready;
  assign in_ready = adv;

  // Valid bits travel with the data
  always_comb begin
    vld_nxt = {vld_r[NUM_STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Per-lane operand reduction and lane round
  logic [63:0] raw [NUM_LANES];
  assign raw[0] = in_operand_a;
  assign raw[1] = in_operand_b;
  assign raw[2] = in_operand_c;

  logic [63:0] mag_r   [NUM_LANES], mag_nxt   [NUM_LANES];
  logic [32:0] sum_r   [NUM_LANES], sum_nxt   [NUM_LANES];
  logic [31:0] fold_r  [NUM_LANES], fold_nxt  [NUM_LANES];
  logic [30:0] rem_r   [NUM_LANES], rem_nxt   [NUM_LANES];
  word_t       word_r  [NUM_LANES], word_nxt  [NUM_LANES];
  word_t       prod_r  [NUM_LANES], prod_nxt  [NUM_LANES];
  word_t       acc_r   [NUM_LANES], acc_nxt   [NUM_LANES];
  word_t       lane_r  [NUM_LANES], lane_nxt  [NUM_LANES];
  logic [3:0]  neg_r   [NUM_LANES], neg_nxt   [NUM_LANES];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      logic [31:0] diff;
      // stage 1: magnitude, sign kept in a small shift line
      mag_nxt[i] = raw[i][63] ? (~raw[i] + 64'd1) : raw[i];
      neg_nxt[i] = {neg_r[i][2:0], raw[i][63]};
      // stage 2: 2^31 == 1, so add the 31-bit chunks
      sum_nxt[i] = {2'b00, mag_r[i][30:0]} + {2'b00, mag_r[i][61:31]}
                 + {31'd0, mag_r[i][63:62]};
      // stage 3: fold again
      fold_nxt[i] = {1'b0, sum_r[i][30:0]} + {30'd0, sum_r[i][32:31]};
      // stage 4: one conditional subtract, value stays below twice the modulus
      diff = fold_r[i] - {1'b0, MOD31};
      rem_nxt[i] = (fold_r[i] >= {1'b0, MOD31}) ? diff[30:0] : fold_r[i][30:0];
      // stage 5: restore sign as a 32-bit two's complement word
      word_nxt[i] = neg_r[i][3] ? word_t'(32'd0 - {1'b0, rem_r[i]})
                                : {1'b0, rem_r[i]};
      // stage 6..8: lane round
      prod_nxt[i] = word_r[i] * PRIME2;
      acc_nxt[i]  = rotl32(word_t'(LANE_INIT[i] + prod_r[i]), 13);
      lane_nxt[i] = acc_r[i] * PRIME1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        mag_r[i]  <= mag_nxt[i];
        neg_r[i]  <= neg_nxt[i];
        sum_r[i]  <= sum_nxt[i];
        fold_r[i] <= fold_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        word_r[i] <= word_nxt[i];
        prod_r[i] <= prod_nxt[i];
        acc_r[i]  <= acc_nxt[i];
        lane_r[i] <= lane_nxt[i];
      end
    end
  end

  // Merge and avalanche
  word_t mrg_a_r, mrg_a_nxt;
  word_t mrg_b_r, mrg_b_nxt;
  word_t h_r,     h_nxt;
  word_t hm_r,    hm_nxt;
  word_t x1_r,    x1_nxt;
  word_t x2_r,    x2_nxt;
  word_t out_r,   out_nxt;
  word_t mix1, mix2;

  always_comb begin
    // stage 9: two partial sums
    mrg_a_nxt = rotl32(lane_r[0], LANE_ROT[0]) + rotl32(lane_r[1], LANE_ROT[1]);
    mrg_b_nxt = rotl32(lane_r[2], LANE_ROT[2]) + MERGE_CONST;
    // stage 10: full merge, rotate
    h_nxt  = rotl32(word_t'(mrg_a_r + mrg_b_r), 17);
    // stage 11..14: avalanche
    hm_nxt = h_r * PRIME4;
    mix1   = hm_r ^ (hm_r >> 15);
    x1_nxt = mix1 * PRIME2;
    mix2   = x1_r ^ (x1_r >> 13);
    x2_nxt = mix2 * PRIME3;
    out_nxt = x2_r ^ (x2_r >> 16);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mrg_a_r <= mrg_a_nxt;
      mrg_b_r <= mrg_b_nxt;
      h_r     <= h_nxt;
      hm_r    <= hm_nxt;
      x1_r    <= x1_nxt;
      x2_r    <= x2_nxt;
      out_r   <= out_nxt;
    end
  end

  assign out_valid      = vld_r[NUM_STAGES-1];
  assign out_hash_value = out_r;

  // Checks
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted word did not enter the first stage");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (rem_r[0] != MOD31 && rem_r[1] != MOD31 && rem_r[2] != MOD31))
    else $error("reduced remainder not below modulus");

endmodule

// ----- tb/sv/xxh_seed_checker.sv -----
// xxh_seed_checker: watches both channels of the three-operand XXH32 seed unit,
// predicts each hash from the accepted operands and compares in order.
// Depends on xxh_pkg for the primes, the modulus, the length and word_t.
`timescale 1ns / 100ps

module xxh_seed_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  input  logic signed [63:0] in_operand_c,
  input  logic               out_valid,
  input  logic               out_ready,
  input  xxh_pkg::word_t     out_hash_value,
  output int                 mismatches,
  output int                 pending
);
  import xxh_pkg::*;

  word_t hash_due [$];

  function automatic word_t rol(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Truncated remainder mod 2^31-1; sign follows the operand
  function automatic word_t mod31_word(input logic [63:0] raw);
    logic [63:0] mag;
    logic [63:0] rem;
    mag = raw[63] ? (64'd0 - raw) : raw;
    rem = mag % {33'd0, MOD31};
    return raw[63] ? (32'd0 - rem[31:0]) : rem[31:0];
  endfunction

  function automatic word_t mul(input word_t x, input word_t y);
    word_t p;
    p = x * y;
    return p;
  endfunction

  function automatic word_t lane_mix(input word_t acc, input word_t w);
    word_t t;
    t = acc + mul(w, PRIME2);
    t = rol(t, 13);
    return mul(t, PRIME1);
  endfunction

  // XXH32, seed 0, over {a', b', c', 0, 0} as a 20-byte message
  function automatic word_t predict_seed_hash(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c);
    word_t w0, w1, w2, w3, w4;
    word_t h;
    w0 = mod31_word(a);
    w1 = mod31_word(b);
    w2 = mod31_word(c);
    w3 = '0;
    w4 = '0;
    h = rol(lane_mix(PRIME1 + PRIME2, w0), 1) + rol(lane_mix(PRIME2, w1), 7)
      + rol(lane_mix(32'd0, w2), 12) + rol(lane_mix(32'd0 - PRIME1, w3), 18);
    h = h + MSG_BYTES;
    h = h + mul(w4, PRIME3);
    h = mul(rol(h, 17), PRIME4);
    h = h ^ (h >> 15);
    h = mul(h, PRIME2);
    h = h ^ (h >> 13);
    h = mul(h, PRIME3);
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    word_t want;
    if (!rst_n) begin
      mismatches = 0;
      pending    = 0;
    end else begin
      if (in_valid && in_ready)
        hash_due.push_back(predict_seed_hash(in_operand_a, in_operand_b, in_operand_c));
      if (out_valid && out_ready) begin
        if (hash_due.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected hash word, expected none, actual %h",
                   $time, out_hash_value);
        end else begin
          want = hash_due.pop_front();
          if (out_hash_value !== want) begin
            mismatches = mismatches + 1;
            $display("%0t: out_hash_value expected %h actual %h",
                     $time, want, out_hash_value);
          end
        end
      end
      pending = hash_due.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// tb: top of the seed unit testbench; makes operand stimulus and back-pressure,
// and reports the verdict. Depends on xxh_pkg, the seed unit and xxh_seed_checker.
`timescale 1ns / 100ps

module tb;
  import xxh_pkg::*;

  localparam int N_RANDOM = 750;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [63:0] in_operand_a;
  logic signed [63:0] in_operand_b;
  logic signed [63:0] in_operand_c;
  logic               out_valid;
  logic               out_ready;
  word_t              out_hash_value;
  int                 mismatches;
  int                 pending;
  int                 words_sent;
  int                 hashes_taken;

  xxhash32_three_operand_seed_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_operand_c   (in_operand_c),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  xxh_seed_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_operand_c   (in_operand_c),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Random operand: full range, small, near a multiple of 2^31-1, or 32-bit with an all-ones or zero upper half
  function automatic logic signed [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2: v = 64'($signed($urandom_range(0, 64))) - 64'd32;
      3: v = 64'($urandom) * 64'(MOD31) + 64'($signed($urandom_range(0, 6))) - 64'd3;
      4: v = 64'($urandom_range(0, 4)) * 64'(MOD31) + 64'($urandom_range(0, 2));
      default: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
    endcase
    if ((v[63] == 1'b0) && ($urandom_range(0, 1) == 1)) v = 64'd0 - v;
    return v;
  endfunction

  // Offer one word after a random gap; returns at the falling edge after acceptance
  task automatic send_word(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c);
    int gap;
    gap = $urandom_range(0, 6);
    if ((words_sent >= 300 && words_sent < 400) || (words_sent >= 600 && words_sent < 660))
      gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operand_c <= c;
    do @(posedge clk); while (!in_ready);
    words_sent = words_sent + 1;
    @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off, and stretches with none
  initial begin
    int stall;
    hashes_taken = 0;
    out_ready    = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 6);
      if ((hashes_taken >= 400 && hashes_taken < 500) ||
          (hashes_taken >= 600 && hashes_taken < 660))
        stall = 0;
      if (hashes_taken == 150) stall = 120;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      hashes_taken = hashes_taken + 1;
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [63:0] edge_val [16];
    int i;
    edge_val = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 64'd2147483647, 64'd0 - 64'd2147483647,
                 64'd4294967294, 64'd2147483646, 64'd0 - 64'd2147483646,
                 64'd2147483648, 64'h4000_0000_0000_0000,
                 64'd9223372036854775806, 64'd0 - 64'd9223372036854775806,
                 64'h8000_0000_0000_0001, 64'hAAAA_5555_0F0F_F0F0};
    words_sent   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_operand_c = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: each corner value on every operand position
    for (i = 0; i < 16; i++)
      send_word(edge_val[i], edge_val[15 - i], edge_val[(i + 5) % 16]);
    send_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_word(64'd2147483647, 64'd0 - 64'd4294967294, 64'd9223372036854775806);
    send_word(64'h5555_AAAA_F0F0_0F0F, 64'hAAAA_5555_0F0F_F0F0, 64'h0123_4567_89AB_CDEF);

    for (i = 0; i < N_RANDOM; i++)
      send_word(pick_operand(), pick_operand(), pick_operand());
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
